@@ src/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the postfix stack calculator
// Widths, action and status codes, controller states and the command and
// flag bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DATA_W      = 32;
  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 9;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;
  localparam int STEP_W      = $clog2(DATA_W);

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH,
    ACT_POP,
    ACT_ADD,
    ACT_SUB,
    ACT_MUL,
    ACT_DIV,
    ACT_READ_TOP,
    ACT_READ_BOT
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_INDEX,
    ST_FEW,
    ST_DIVZERO,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_OPB,
    S_OPA,
    S_DIVIDE,
    S_WRBACK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_FROM_TOP,
    RD_FROM_BOT
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_VALUE,
    RES_MEM,
    RES_ALU,
    RES_QUOT
  } res_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_DEC2
  } cnt_op_t;

  typedef enum logic {
    WR_PUSH,
    WR_RESULT
  } wr_sel_t;

  typedef struct packed {
    logic     load_item;
    rd_sel_t  rd_sel;
    logic     cap_b;
    logic     res_en;
    res_sel_t res_sel;
    logic     set_status;
    status_t  status;
    logic     wr_en;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    logic     div_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    empty;
    logic    few;
    logic    index_oob;
    logic    b_zero;
    logic    div_done;
    logic    out_free;
  } flags_t;

endpackage

`default_nettype wire

@@ src/psc_div.sv @@
// ----------------------------------------------------------------------------
// psc_div: iterative signed floor divider
// Radix-2 restoring division of the magnitudes, one quotient bit a cycle,
// followed by a step that applies the sign and the floor correction.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_div
  import psc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  logic              busy;
  logic              fix;
  logic [STEP_W-1:0] step;
  logic              neg_q;
  logic [DATA_W-1:0] mb;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic              rem_nz;

  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, mb};
  assign ge      = shifted >= {1'b0, mb};
  assign rem_nz  = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
      end else if (busy) begin
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step  <= '0;
      rem   <= '0;
      quo   <= dividend[DATA_W-1] ? ('0 - dividend) : dividend;
      mb    <= divisor[DATA_W-1] ? ('0 - divisor) : divisor;
      neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo  <= {quo[DATA_W-2:0], ge};
      step <= step + STEP_W'(1);
    end else if (fix) begin
      // Differing signs: negate, rounding toward minus infinity.
      quotient <= neg_q ? ('0 - (quo + DATA_W'(rem_nz))) : quo;
    end
  end

endmodule

`default_nettype wire

@@ src/psc_dpath.sv @@
// ----------------------------------------------------------------------------
// psc_dpath: datapath of the postfix stack calculator
// Stack memory, element count, item and operand registers, adder and
// multiplier, the divider, and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_dpath
  import psc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output flags_t                   flags,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [DATA_W-1:0]   in_value,
  input  wire logic [INDEX_W-1:0]  in_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [DATA_W-1:0]   out_result,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [DEPTH_W-1:0]  out_depth
);

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]  wr_data;

  action_t            action;
  logic [DATA_W-1:0]  value;
  logic [INDEX_W-1:0] index;
  logic [CNT_W-1:0]   count;
  logic [DATA_W-1:0]  b_reg;
  logic [DATA_W-1:0]  res;
  status_t            status;
  logic [DATA_W-1:0]  alu;
  logic               div_done;
  logic [DATA_W-1:0]  quot;

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:      rd_addr = PTR_W'(count - CNT_W'(1));
      RD_SECOND:   rd_addr = PTR_W'(count - CNT_W'(2));
      RD_FROM_TOP: rd_addr = PTR_W'(CMP_W'(count) - CMP_W'(1) - CMP_W'(index));
      RD_FROM_BOT: rd_addr = PTR_W'(index);
      default:     rd_addr = PTR_W'(index);
    endcase
  end

  assign wr_addr = (cmd.wr_sel == WR_PUSH) ? PTR_W'(count) : PTR_W'(count - CNT_W'(2));
  assign wr_data = (cmd.wr_sel == WR_PUSH) ? value : res;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Second operand (a) comes straight from the memory read data.
  always_comb begin
    case (action)
      ACT_ADD: alu = rdata + b_reg;
      ACT_SUB: alu = rdata - b_reg;
      default: alu = DATA_W'(rdata * b_reg);
    endcase
  end

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action <= action_t'(in_action);
      value  <= in_value;
      index  <= in_index;
    end
    if (cmd.cap_b) begin
      b_reg <= rdata;
    end
    if (cmd.res_en) begin
      case (cmd.res_sel)
        RES_VALUE: res <= value;
        RES_MEM:   res <= rdata;
        RES_ALU:   res <= alu;
        RES_QUOT:  res <= quot;
        default:   res <= '0;
      endcase
    end
    if (cmd.load_item) begin
      status <= ST_OK;
    end else if (cmd.set_status) begin
      status <= cmd.status;
    end
    if (cmd.out_load) begin
      out_result <= res;
      out_status <= status;
      out_depth  <= DEPTH_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC:  count <= count + CNT_W'(1);
        CNT_DEC:  count <= count - CNT_W'(1);
        CNT_DEC2: count <= count - CNT_W'(2);
        default:  count <= count;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    flags.action    = action;
    flags.full      = count == CNT_W'(STACK_DEPTH);
    flags.empty     = count == '0;
    flags.few       = count < CNT_W'(2);
    flags.index_oob = CMP_W'(index) >= CMP_W'(count);
    flags.b_zero    = b_reg == '0;
    flags.div_done  = div_done;
    flags.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

@@ src/psc_ctrl.sv @@
// ----------------------------------------------------------------------------
// psc_ctrl: controller of the postfix stack calculator
// Sequences each action through decode, memory reads, arithmetic, write
// back and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_ctrl
  import psc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire flags_t flags,
  output cmd_t        cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RD_TOP;
    cmd.res_sel    = RES_ZERO;
    cmd.status     = ST_OK;
    cmd.wr_sel     = WR_PUSH;
    cmd.cnt_op     = CNT_HOLD;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_en = 1'b1;
        case (flags.action)
          ACT_PUSH: begin
            if (flags.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.cnt_op  = CNT_INC;
              cmd.res_sel = RES_VALUE;
            end
            state_next = S_DONE;
          end
          ACT_POP: begin
            if (flags.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_DONE;
            end else begin
              state_next = S_FETCH;
            end
          end
          ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
            if (flags.few) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FEW;
              state_next     = S_DONE;
            end else begin
              state_next = S_OPB;
            end
          end
          default: begin
            cmd.rd_sel = (flags.action == ACT_READ_TOP) ? RD_FROM_TOP : RD_FROM_BOT;
            if (flags.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_DONE;
            end else if (flags.index_oob) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_INDEX;
              state_next     = S_DONE;
            end else begin
              state_next = S_FETCH;
            end
          end
        endcase
      end
      S_FETCH: begin
        cmd.res_en  = 1'b1;
        cmd.res_sel = RES_MEM;
        if (flags.action == ACT_POP) begin
          cmd.cnt_op = CNT_DEC;
        end
        state_next = S_DONE;
      end
      S_OPB: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_sel = RD_SECOND;
        state_next = S_OPA;
      end
      S_OPA: begin
        if (flags.action == ACT_DIV) begin
          if (flags.b_zero) begin
            cmd.res_en     = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_DIVZERO;
            cmd.cnt_op     = CNT_DEC2;
            state_next     = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIVIDE;
          end
        end else begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_ALU;
          state_next  = S_WRBACK;
        end
      end
      S_DIVIDE: begin
        if (flags.div_done) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_QUOT;
          state_next  = S_WRBACK;
        end
      end
      S_WRBACK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RESULT;
        cmd.cnt_op = CNT_DEC;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/postfix_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// postfix_stack_calculator: signed 32-bit operand stack for postfix evaluation
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
//
// Each input item carries one action (push, pop, add, subtract, multiply,
// divide, read counted from the top, read counted from the bottom) and
// returns exactly one result item holding the value, a status code and the
// stack depth after the action. The block handles one item at a time. A
// zero divisor is reported only after both operands are fetched, because
// the divisor is tested after that fetch. Divide uses the radix-2 divider,
// which resolves one quotient bit per cycle and then applies the sign and
// floor correction. The stack lives in a 256-word memory with one write and
// one registered read port, so the two operands of an arithmetic action are
// fetched one after the other, the second in the cycle after the first. A
// finished result sits in the output register, and a new item is accepted
// while it waits.
// The stack is empty after reset; no clearing pass is needed.
//
`default_nettype none

module postfix_stack_calculator
  import psc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], index[39:32]
  input  wire logic [2:0]  s_tuser,   // action[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // result[31:0], depth[40:32], zero[47:41]
  output logic      [2:0]  m_tuser    // status[2:0]
);

  cmd_t                cmd;
  flags_t              flags;
  logic [DATA_W-1:0]   out_result;
  logic [STATUS_W-1:0] out_status;
  logic [DEPTH_W-1:0]  out_depth;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  psc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .flags      (flags),
    .in_action  (s_tuser),
    .in_value   (s_tdata[31:0]),
    .in_index   (s_tdata[39:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result),
    .out_status (out_status),
    .out_depth  (out_depth)
  );

  assign m_tdata = {7'b0, out_depth, out_result};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
